// ===== design/frame_delta_timebase_assert.svh =====
// assertion macros for the timebase rtl
`ifndef FRAME_DELTA_TIMEBASE_ASSERT_SVH
`define FRAME_DELTA_TIMEBASE_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define FDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timebase assertion failed");

// next-cycle implication on clk, off during reset
`define FDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timebase assertion failed");

`endif

// ===== design/fdt_pkg.sv =====
// types and constants for the frame delta timebase
`default_nettype none

package fdt_pkg;

  // counter and frame timing
  localparam int unsigned TickRate  = 294912000;
  localparam int unsigned FrameRate = 60;
  localparam int unsigned FrameTicksInt = TickRate / FrameRate;

  localparam int CLAMP_W = 24;
  localparam int RATE_W  = 32;
  localparam int PROD_W  = CLAMP_W + RATE_W;
  localparam int SCALE_LSB = 24;

  localparam logic [63:0] FRAME_TICKS   = 64'(FrameTicksInt);
  localparam logic [63:0] FRAME_TICKS_2 = 64'(2 * FrameTicksInt);
  localparam logic [CLAMP_W-1:0] CLAMP_MIN = CLAMP_W'(FrameTicksInt);
  localparam logic [CLAMP_W-1:0] CLAMP_MAX = CLAMP_W'(2 * FrameTicksInt);
  localparam logic [31:0] SCALED_FRAME = 32'(FrameTicksInt);

  // register reset values
  localparam logic [15:0] RATE_ONE = 16'd4096;

  // configuration register indexes
  localparam logic [1:0] CFG_CLOCK_RATE    = 2'd0;
  localparam logic [1:0] CFG_POWERUP_RATE  = 2'd1;
  localparam logic [1:0] CFG_CLOCK_ENABLED = 2'd2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_MARK  = 2'd1,
    OP_REAL  = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXT   = 7'b0000010,
    S_DELTA = 7'b0000100,
    S_CLAMP = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [15:0] clock_rate;
    logic [15:0] powerup_rate;
    logic        clock_enabled;
  } cfg_t;

  typedef struct packed {
    logic [63:0] game_time;
    logic [63:0] real_time;
    logic [31:0] scaled_delta;
    logic [31:0] previous_delta;
    logic [63:0] real_delta;
  } result_t;

  typedef struct packed {
    logic               en;
    logic [CLAMP_W-1:0] a;
    logic [RATE_W-1:0]  b;
  } mul_req_t;

endpackage

`default_nettype wire

// ===== design/fdt_mul.sv =====
// shared multiplier with registered product
`default_nettype none

module fdt_mul (
  input  wire logic              clk,
  input  wire fdt_pkg::mul_req_t req,
  output logic [fdt_pkg::PROD_W-1:0] prod
);

  logic [fdt_pkg::PROD_W-1:0] prod_r;
  logic [fdt_pkg::PROD_W-1:0] prod_nxt;

  // one multiply per enabled cycle
  assign prod_nxt = fdt_pkg::PROD_W'(req.a) * fdt_pkg::PROD_W'(req.b);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== design/fdt_core.sv =====
// sequencer and timebase state, driving the shared multiplier
`default_nettype none
`include "frame_delta_timebase_assert.svh"

module fdt_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_op,
  input  wire logic [31:0]      in_raw_count,
  input  wire logic [63:0]      in_new_time,
  input  wire fdt_pkg::cfg_t    cfg,
  input  wire logic             res_free,
  output logic                  done,
  output fdt_pkg::result_t      res
);

  fdt_pkg::state_t state_r, state_nxt;
  fdt_pkg::op_t    op_r, op_nxt;

  // item payload and scratch
  logic [31:0] raw_r, raw_nxt;
  logic [63:0] new_time_r, new_time_nxt;
  logic [63:0] now_r, now_nxt;
  logic [63:0] delta_r, delta_nxt;
  logic [fdt_pkg::CLAMP_W-1:0] clamp_r, clamp_nxt;

  // timebase state
  logic [31:0] wrap_r, wrap_nxt;
  logic [31:0] last_raw_r, last_raw_nxt;
  logic [63:0] frame_tick_r, frame_tick_nxt;
  logic [63:0] game_r, game_nxt;
  logic [63:0] real_r, real_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [63:0] last_real_r, last_real_nxt;

  fdt_pkg::mul_req_t mul_req;
  logic [fdt_pkg::PROD_W-1:0] prod;
  logic [31:0] wrap_inc;
  logic [31:0] scaled;
  logic [63:0] real_sel;

  fdt_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // wrap detect on the new sample
  assign wrap_inc = (raw_r < last_raw_r) ? (wrap_r + 32'd1) : wrap_r;

  // scaled delta and the real delta that goes with it
  always_comb begin
    scaled = cfg.clock_enabled ? prod[fdt_pkg::SCALE_LSB +: 32] : 32'd0;
    if (scaled >= fdt_pkg::SCALED_FRAME) begin
      real_sel = {32'd0, scaled};
    end else begin
      real_sel = {{(64 - fdt_pkg::CLAMP_W){1'b0}}, clamp_r};
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    raw_nxt        = raw_r;
    new_time_nxt   = new_time_r;
    now_nxt        = now_r;
    delta_nxt      = delta_r;
    clamp_nxt      = clamp_r;
    wrap_nxt       = wrap_r;
    last_raw_nxt   = last_raw_r;
    frame_tick_nxt = frame_tick_r;
    game_nxt       = game_r;
    real_nxt       = real_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    last_real_nxt  = last_real_r;
    mul_req.en     = 1'b0;
    mul_req.a      = clamp_r;
    mul_req.b      = prod[fdt_pkg::RATE_W-1:0];
    done           = 1'b0;

    unique case (state_r)
      fdt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt       = fdt_pkg::op_t'(in_op);
          raw_nxt      = in_raw_count;
          new_time_nxt = in_new_time;
          state_nxt    = fdt_pkg::S_EXT;
        end
      end
      fdt_pkg::S_EXT: begin
        if (op_r == fdt_pkg::OP_SET) begin
          game_nxt  = new_time_r;
          state_nxt = fdt_pkg::S_DONE;
        end else begin
          wrap_nxt     = wrap_inc;
          last_raw_nxt = raw_r;
          now_nxt      = {wrap_inc, raw_r};
          if (op_r == fdt_pkg::OP_START) begin
            frame_tick_nxt = {wrap_inc, raw_r};
            state_nxt      = fdt_pkg::S_DONE;
          end else begin
            state_nxt = fdt_pkg::S_DELTA;
          end
        end
      end
      fdt_pkg::S_DELTA: begin
        // delta since reference, and first multiplier pass forms the rate
        delta_nxt      = now_r - frame_tick_r;
        frame_tick_nxt = now_r;
        mul_req.en     = 1'b1;
        mul_req.a      = fdt_pkg::CLAMP_W'(cfg.clock_rate);
        mul_req.b      = fdt_pkg::RATE_W'(cfg.powerup_rate);
        state_nxt      = (op_r == fdt_pkg::OP_MARK) ? fdt_pkg::S_CLAMP : fdt_pkg::S_UPD;
      end
      fdt_pkg::S_CLAMP: begin
        priority if (delta_r < fdt_pkg::FRAME_TICKS) begin
          clamp_nxt = fdt_pkg::CLAMP_MIN;
        end else if (delta_r > fdt_pkg::FRAME_TICKS_2) begin
          clamp_nxt = fdt_pkg::CLAMP_MAX;
        end else begin
          clamp_nxt = delta_r[fdt_pkg::CLAMP_W-1:0];
        end
        state_nxt = fdt_pkg::S_SCALE;
      end
      fdt_pkg::S_SCALE: begin
        // second multiplier pass: clamped delta times rate
        mul_req.en = 1'b1;
        mul_req.a  = clamp_r;
        mul_req.b  = prod[fdt_pkg::RATE_W-1:0];
        state_nxt  = fdt_pkg::S_UPD;
      end
      fdt_pkg::S_UPD: begin
        if (op_r == fdt_pkg::OP_MARK) begin
          last_real_nxt = real_sel;
          game_nxt      = game_r + {32'd0, scaled};
          prev_nxt      = cur_r;
          cur_nxt       = scaled;
          real_nxt      = real_r + real_sel;
        end else begin
          last_real_nxt = delta_r;
          real_nxt      = real_r + delta_r;
        end
        state_nxt = fdt_pkg::S_DONE;
      end
      fdt_pkg::S_DONE: begin
        done = 1'b1;
        if (res_free) begin
          state_nxt = fdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fdt_pkg::S_IDLE;
      end
    endcase
  end

  // control and timebase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fdt_pkg::S_IDLE;
      wrap_r       <= 32'd0;
      last_raw_r   <= 32'd0;
      frame_tick_r <= 64'd0;
      game_r       <= 64'd0;
      real_r       <= 64'd0;
      cur_r        <= 32'd0;
      prev_r       <= 32'd0;
      last_real_r  <= 64'd0;
    end else begin
      state_r      <= state_nxt;
      wrap_r       <= wrap_nxt;
      last_raw_r   <= last_raw_nxt;
      frame_tick_r <= frame_tick_nxt;
      game_r       <= game_nxt;
      real_r       <= real_nxt;
      cur_r        <= cur_nxt;
      prev_r       <= prev_nxt;
      last_real_r  <= last_real_nxt;
    end
  end

  // item payload and scratch
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    raw_r      <= raw_nxt;
    new_time_r <= new_time_nxt;
    now_r      <= now_nxt;
    delta_r    <= delta_nxt;
    clamp_r    <= clamp_nxt;
  end

  assign in_ready = (state_r == fdt_pkg::S_IDLE);

  assign res.game_time      = game_r;
  assign res.real_time      = real_r;
  assign res.scaled_delta   = cur_r;
  assign res.previous_delta = prev_r;
  assign res.real_delta     = last_real_r;

  // checks
  `FDT_ASSERT_NXT(a_accept_to_ext, in_valid && in_ready, state_r == fdt_pkg::S_EXT)
  `FDT_ASSERT_IMP(a_clamp_range, state_r == fdt_pkg::S_SCALE, (clamp_r >= fdt_pkg::CLAMP_MIN) && (clamp_r <= fdt_pkg::CLAMP_MAX))
  `FDT_ASSERT_IMP(a_clamp_mark_only, (state_r == fdt_pkg::S_CLAMP) || (state_r == fdt_pkg::S_SCALE), op_r == fdt_pkg::OP_MARK)
  `FDT_ASSERT_NXT(a_wrap_hold, state_r != fdt_pkg::S_EXT, $stable(wrap_r))

endmodule

`default_nettype wire

// ===== design/frame_delta_timebase.sv =====
// Steps: an accepted item is first extended from its counter sample, or for set time
// loads game time; start and set time then finish, mark real only goes on through
// delta and update, and mark frame through delta, clamp, scale and update. A new item
// is taken only after the last is done; mark frame uses the one shared multiplier twice.
// An output register holds the result, so a new item is taken while it waits.
// Synchronous active-low reset clears all timebase state and restores the rate registers.
`default_nettype none

module frame_delta_timebase (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_raw_count,
  input  wire logic [63:0] in_new_time,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_game_time,
  output logic [63:0]      out_real_time,
  output logic [31:0]      out_scaled_delta,
  output logic [31:0]      out_previous_delta,
  output logic [63:0]      out_real_delta,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  fdt_pkg::cfg_t    cfg_r, cfg_nxt;
  fdt_pkg::result_t res;
  fdt_pkg::result_t res_r;
  logic             out_valid_r, out_valid_nxt;
  logic             done;
  logic             res_free;

  fdt_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_raw_count (in_raw_count),
    .in_new_time  (in_new_time),
    .cfg          (cfg_r),
    .res_free     (res_free),
    .done         (done),
    .res          (res)
  );

  // configuration register writes
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        fdt_pkg::CFG_CLOCK_RATE:    cfg_nxt.clock_rate    = cfg_data;
        fdt_pkg::CFG_POWERUP_RATE:  cfg_nxt.powerup_rate  = cfg_data;
        fdt_pkg::CFG_CLOCK_ENABLED: cfg_nxt.clock_enabled = cfg_data[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  // output register slot
  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done && res_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_rate    <= fdt_pkg::RATE_ONE;
      cfg_r.powerup_rate  <= fdt_pkg::RATE_ONE;
      cfg_r.clock_enabled <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_free) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_game_time      = res_r.game_time;
  assign out_real_time      = res_r.real_time;
  assign out_scaled_delta   = res_r.scaled_delta;
  assign out_previous_delta = res_r.previous_delta;
  assign out_real_delta     = res_r.real_delta;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for the frame delta timebase
`default_nettype none

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned FRAME = fdt_pkg::FrameTicksInt;
  // index with no register behind it
  localparam logic [1:0] CFG_NO_REG = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = fdt_pkg::OP_START;
  logic [31:0] in_raw_count = '0;
  logic [63:0] in_new_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_game_time;
  logic [63:0] out_real_time;
  logic [31:0] out_scaled_delta;
  logic [31:0] out_previous_delta;
  logic [63:0] out_real_delta;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = fdt_pkg::CFG_CLOCK_RATE;
  logic [15:0] cfg_data = '0;

  // shadow registers and timebase state of the predictor
  logic [15:0] sh_clock_rate = fdt_pkg::RATE_ONE;
  logic [15:0] sh_powerup_rate = fdt_pkg::RATE_ONE;
  logic        sh_clock_en = 1'b0;
  logic [31:0] tb_wraps = '0;
  logic [31:0] tb_last_raw = '0;
  logic [63:0] tb_frame_ref = '0;
  logic [63:0] tb_game = '0;
  logic [63:0] tb_real = '0;
  logic [31:0] tb_cur_delta = '0;
  logic [31:0] tb_prev_delta = '0;
  logic [63:0] tb_real_delta = '0;

  fdt_pkg::result_t pending_times[$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          stall_left = 0;
  logic [31:0] raw_cursor = '0;

  frame_delta_timebase uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_raw_count       (in_raw_count),
    .in_new_time        (in_new_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_game_time      (out_game_time),
    .out_real_time      (out_real_time),
    .out_scaled_delta   (out_scaled_delta),
    .out_previous_delta (out_previous_delta),
    .out_real_delta     (out_real_delta),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // extend a counter sample to 64 bits, counting wraps
  function automatic logic [63:0] extend_raw(logic [31:0] raw);
    if (raw < tb_last_raw) tb_wraps = tb_wraps + 32'd1;
    tb_last_raw = raw;
    return {tb_wraps, raw};
  endfunction

  // timebase update for one item, returns the state after it
  function automatic fdt_pkg::result_t advance_timebase(fdt_pkg::op_t op,
                                                        logic [31:0] raw,
                                                        logic [63:0] nt);
    logic [63:0] now;
    logic [63:0] span;
    logic [63:0] real_step;
    logic [63:0] scaled;
    logic [31:0] rate;
    fdt_pkg::result_t r;
    case (op)
      fdt_pkg::OP_START: begin
        now = extend_raw(raw);
        tb_frame_ref = now;
      end
      fdt_pkg::OP_MARK: begin
        now = extend_raw(raw);
        span = now - tb_frame_ref;
        if (span < fdt_pkg::FRAME_TICKS) span = fdt_pkg::FRAME_TICKS;
        else if (span > fdt_pkg::FRAME_TICKS_2) span = fdt_pkg::FRAME_TICKS_2;
        real_step = span;
        rate = {16'd0, sh_clock_rate} * {16'd0, sh_powerup_rate};
        scaled = sh_clock_en ? ((span * {32'd0, rate}) >> 24) : 64'd0;
        scaled = {32'd0, scaled[31:0]};
        // a scaled step of a frame or more stands in for the real step
        if (scaled >= fdt_pkg::FRAME_TICKS) real_step = scaled;
        tb_real_delta = real_step;
        tb_game = tb_game + scaled;
        tb_prev_delta = tb_cur_delta;
        tb_cur_delta = scaled[31:0];
        tb_real = tb_real + real_step;
        tb_frame_ref = now;
      end
      fdt_pkg::OP_REAL: begin
        now = extend_raw(raw);
        span = now - tb_frame_ref;
        tb_real_delta = span;
        tb_real = tb_real + span;
        tb_frame_ref = now;
      end
      default: begin
        tb_game = nt;
      end
    endcase
    r.game_time = tb_game;
    r.real_time = tb_real;
    r.scaled_delta = tb_cur_delta;
    r.previous_delta = tb_prev_delta;
    r.real_delta = tb_real_delta;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_sample(fdt_pkg::op_t op, logic [31:0] raw, logic [63:0] nt);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_raw_count <= raw;
    in_new_time <= nt;
    do @(posedge clk); while (!in_ready);
    pending_times.push_back(advance_timebase(op, raw, nt));
  endtask

  // hold the input side until every pending result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_times.size() != 0);
  endtask

  // one register write transfer, after which valid goes low
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fdt_pkg::CFG_CLOCK_RATE:    sh_clock_rate = data;
      fdt_pkg::CFG_POWERUP_RATE:  sh_powerup_rate = data;
      fdt_pkg::CFG_CLOCK_ENABLED: sh_clock_en = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic reconfigure(logic [15:0] rate_a, logic [15:0] rate_b, logic en);
    drain_results();
    write_reg(fdt_pkg::CFG_CLOCK_RATE, rate_a);
    write_reg(fdt_pkg::CFG_POWERUP_RATE, rate_b);
    write_reg(fdt_pkg::CFG_CLOCK_ENABLED, {15'd0, en});
  endtask

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return fdt_pkg::RATE_ONE;
      default: return 16'($urandom);
    endcase
  endfunction

  // mark, real-only, set time and start right after reset, with the clock still disabled
  task automatic test_after_reset();
    send_sample(fdt_pkg::OP_MARK, 32'd100, '0);
    send_sample(fdt_pkg::OP_REAL, 32'h20, '1);
    send_sample(fdt_pkg::OP_SET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(fdt_pkg::OP_START, 32'hFFFF_FFFF, '0);
  endtask

  // clamp edges, counter wrap, real-only and game time loads
  task automatic test_directed_ops();
    drain_results();
    write_reg(fdt_pkg::CFG_CLOCK_ENABLED, 16'd1);
    raw_cursor = 32'd0;
    send_sample(fdt_pkg::OP_START, raw_cursor, '0);
    raw_cursor = raw_cursor + FRAME - 1;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    raw_cursor = raw_cursor + FRAME;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    raw_cursor = raw_cursor + 2 * FRAME;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    raw_cursor = raw_cursor + 2 * FRAME + 1;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    raw_cursor = raw_cursor + 32'h7FFF_FFFF;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    raw_cursor = raw_cursor + 32'd12345;
    send_sample(fdt_pkg::OP_REAL, raw_cursor, '0);
    send_sample(fdt_pkg::OP_SET, 32'h0, 64'd0);
    send_sample(fdt_pkg::OP_SET, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    raw_cursor = raw_cursor + FRAME;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
  endtask

  // zero, maximum and fractional rates, plus the unused index
  task automatic test_rate_extremes();
    reconfigure(16'd0, fdt_pkg::RATE_ONE, 1'b1);
    raw_cursor = raw_cursor + FRAME;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    reconfigure(16'hFFFF, 16'hFFFF, 1'b1);
    raw_cursor = raw_cursor + 2 * FRAME;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    reconfigure(16'd2048, fdt_pkg::RATE_ONE, 1'b1);
    raw_cursor = raw_cursor + FRAME;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
    drain_results();
    write_reg(CFG_NO_REG, 16'hFFFF);
    raw_cursor = raw_cursor + FRAME + 77;
    send_sample(fdt_pkg::OP_MARK, raw_cursor, '0);
  endtask

  // mostly frame-paced samples, some noise, optional full pauses
  task automatic run_frame_stream(int count, bit with_pauses);
    int           pick;
    fdt_pkg::op_t op;
    logic [31:0]  raw;
    logic [63:0]  nt;
    for (int i = 0; i < count; i++) begin
      nt = {$urandom, $urandom};
      if ($urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) op = fdt_pkg::OP_MARK;
        else if (pick < 16) op = fdt_pkg::OP_REAL;
        else if (pick < 18) op = fdt_pkg::OP_START;
        else op = fdt_pkg::OP_SET;
        if (op == fdt_pkg::OP_SET) begin
          raw = $urandom;
          if ($urandom_range(0, 1) == 0) nt = tb_game + 64'($urandom_range(0, 1000));
        end else begin
          case ($urandom_range(0, 9))
            0: raw_cursor = raw_cursor + $urandom_range(0, FRAME);
            1: raw_cursor = raw_cursor + $urandom;
            default: raw_cursor = raw_cursor + $urandom_range(FRAME - 2000, 2 * FRAME + 2000);
          endcase
          raw = raw_cursor;
        end
      end else begin
        op = fdt_pkg::op_t'($urandom_range(0, 3));
        raw = $urandom;
        if (op != fdt_pkg::OP_SET) raw_cursor = raw;
      end
      send_sample(op, raw, nt);
      if (with_pauses && $urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic test_random_streams();
    reconfigure(fdt_pkg::RATE_ONE, fdt_pkg::RATE_ONE, 1'b1);
    run_frame_stream(300, 1'b0);
    reconfigure(pick_rate(), pick_rate(), 1'b1);
    run_frame_stream(300, 1'b0);
    reconfigure(pick_rate(), pick_rate(), 1'b1);
    run_frame_stream(300, 1'b1);
    reconfigure(16'hFFFF, 16'hFFFF, 1'b1);
    run_frame_stream(300, 1'b0);
    reconfigure(pick_rate(), pick_rate(), 1'($urandom_range(0, 1)));
    run_frame_stream(300, 1'b0);
    // last stretch runs back to back on both sides
    reconfigure(pick_rate(), pick_rate(), 1'b1);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_frame_stream(300, 1'b0);
  endtask

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest pending state
  always @(posedge clk) begin : check_results
    fdt_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_times.size() == 0) begin
        flag_mismatch("result transfer with nothing pending");
      end else begin
        want = pending_times.pop_front();
        check_field("game_time", out_game_time, want.game_time);
        check_field("real_time", out_real_time, want.real_time);
        check_field("scaled_delta", {32'd0, out_scaled_delta}, {32'd0, want.scaled_delta});
        check_field("previous_delta", {32'd0, out_previous_delta},
                    {32'd0, want.previous_delta});
        check_field("real_delta", out_real_delta, want.real_delta);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL frame_delta_timebase");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_directed_ops();
    test_rate_extremes();
    test_random_streams();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_times.size() == 0) begin
      $display("PASS frame_delta_timebase");
    end else begin
      $display("FAIL frame_delta_timebase");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/fdt_pkg.sv
design/fdt_mul.sv
design/fdt_core.sv
design/frame_delta_timebase.sv
tb/sv/tb.sv
